/* hw/rtl/prim_maze_carver_defines.svh */
// assertion macros for the maze carver
`ifndef PRIM_MAZE_CARVER_DEFINES_SVH
`define PRIM_MAZE_CARVER_DEFINES_SVH

// property holds in the cycle after the trigger
`define PMC_ASSERT_NEXT(label, clk, rst, trig, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (prop)) \
    else $error("assertion failed");

// property holds in the same cycle as the trigger
`define PMC_ASSERT_NOW(label, clk, rst, trig, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (prop)) \
    else $error("assertion failed");

`endif

/* hw/rtl/pmc_pkg.sv */
`default_nettype none
package pmc_pkg;

  localparam int MAX_ROWS = 32;
  localparam int MAX_COLS = 32;
  localparam int CELLS = MAX_ROWS * MAX_COLS;
  localparam int RW = $clog2(MAX_ROWS);
  localparam int CW = $clog2(MAX_COLS);
  localparam int IW = RW + CW;
  localparam int NW = $clog2(CELLS + 1);
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 6;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 1'd1;

  localparam logic [1:0] MARK_NONE = 2'd0;
  localparam logic [1:0] MARK_BOUND = 2'd1;
  localparam logic [1:0] MARK_DISC = 2'd2;

  typedef struct packed {
    logic        restart;
    logic [15:0] rand_start_row;
    logic [15:0] rand_start_col;
    logic [15:0] rand_pick;
    logic [15:0] rand_neighbor;
  } in_word_t;

  typedef struct packed {
    logic       wall_kind;
    logic [4:0] wall_row;
    logic [4:0] wall_col;
    logic       maze_done;
  } out_word_t;

  // divider handshake
  typedef struct packed {
    logic        start;
    logic [15:0] num;
    logic [NW-1:0] den;
  } div_req_t;

endpackage
`default_nettype wire

/* hw/rtl/prim_maze_carver.sv */
`default_nettype none
// Randomized Prim maze carver. Each accepted word on the input channel
// performs one carving step and yields at most one removed wall on the
// output channel. A plain step takes two remainders (list pick, then
// neighbour pick) through one shared shift-subtract unit, and reads and
// writes of the single-port mark memory and the boundary list.
// A word with restart set first runs a clearing pass over the 1024-entry
// mark memory, one entry a cycle, then takes the start cell from the start
// randoms modulo the grid size (two more remainders) before its step
// begins. The block accepts no new word while a step is in progress or
// while its wall waits to be taken. Register writes stop the running maze
// until a restart.
`include "prim_maze_carver_defines.svh"
module prim_maze_carver import pmc_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire in_word_t             in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output out_word_t                 out_data,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);
  // sequencer states
  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_CLEAR  = 5'd1;
  localparam logic [4:0] S_MODR   = 5'd2;
  localparam logic [4:0] S_MODC   = 5'd3;
  localparam logic [4:0] S_MARK   = 5'd4;
  localparam logic [4:0] S_NRD    = 5'd5;
  localparam logic [4:0] S_NCHK   = 5'd6;
  localparam logic [4:0] S_PICK   = 5'd7;
  localparam logic [4:0] S_LRD    = 5'd8;
  localparam logic [4:0] S_LGET   = 5'd9;
  localparam logic [4:0] S_BRD    = 5'd10;
  localparam logic [4:0] S_BCHK   = 5'd11;
  localparam logic [4:0] S_KMOD   = 5'd12;
  localparam logic [4:0] S_LAST   = 5'd13;
  localparam logic [4:0] S_LLGET  = 5'd14;
  localparam logic [4:0] S_OUT    = 5'd15;
  localparam logic [4:0] S_WAITM  = 5'd16;

  logic [4:0]   state;
  logic [4:0]   after_mod;
  in_word_t     item;
  logic [5:0]   grid_rows, grid_cols;
  logic [RW:0]  rows;
  logic [CW:0]  cols;
  logic [NW-1:0] fcount, dcount;
  logic [IW-1:0] cur, pick_cell;
  logic         running;
  logic [NW-1:0] sel;
  logic [1:0]   dir;
  logic [2:0]   ncount;
  logic [1:0]   nlist [4];
  logic [IW:0]  clr;

  // memories
  logic [1:0]    mark_mem [CELLS];
  logic [IW-1:0] list_mem [CELLS];
  logic          mark_we, list_we;
  logic [IW-1:0] mark_addr, list_waddr, list_raddr, list_wdata;
  logic [1:0]    mark_wdata, mark_q;
  logic [IW-1:0] list_q;

  always_ff @(posedge clk) begin
    if (mark_we) mark_mem[mark_addr] <= mark_wdata;
    mark_q <= mark_mem[mark_addr];
  end
  always_ff @(posedge clk) begin
    if (list_we) list_mem[list_waddr] <= list_wdata;
    list_q <= list_mem[list_raddr];
  end

  // shared remainder unit
  div_req_t      dreq;
  logic          dbusy;
  logic [NW-1:0] drem;
  pmc_mod_unit u_mod (.clk(clk), .rst(rst), .req(dreq), .busy(dbusy), .rem(drem));

  // clamped grid size
  always_comb begin
    rows = (grid_rows == 6'd0) ? (RW+1)'(1) :
           (grid_rows > 6'(MAX_ROWS)) ? (RW+1)'(MAX_ROWS) : (RW+1)'(grid_rows);
    cols = (grid_cols == 6'd0) ? (CW+1)'(1) :
           (grid_cols > 6'(MAX_COLS)) ? (CW+1)'(MAX_COLS) : (CW+1)'(grid_cols);
  end

  logic [NW-1:0] total;
  assign total = NW'(rows) * NW'(cols);

  // neighbour of a cell in direction up, left, down, right
  logic [IW-1:0] base;
  logic [RW-1:0] br;
  logic [CW-1:0] bc;
  logic          nb_ok;
  logic [IW-1:0] nb_idx;
  logic [1:0]    ndir;
  assign base = (state == S_NRD || state == S_NCHK) ? cur : pick_cell;
  assign br = base[IW-1:CW];
  assign bc = base[CW-1:0];
  assign ndir = (state == S_OUT) ? nlist[drem[1:0]] : dir;
  always_comb begin
    nb_ok = 1'b0;
    nb_idx = base;
    case (ndir)
      2'd0: begin
        nb_ok = br != '0;
        nb_idx = {br - RW'(1), bc};
      end
      2'd1: begin
        nb_ok = bc != '0;
        nb_idx = {br, bc - CW'(1)};
      end
      2'd2: begin
        nb_ok = (RW+1)'(br) + (RW+1)'(1) < rows;
        nb_idx = {br + RW'(1), bc};
      end
      default: begin
        nb_ok = (CW+1)'(bc) + (CW+1)'(1) < cols;
        nb_idx = {br, bc + CW'(1)};
      end
    endcase
  end

  // memory port control
  always_comb begin
    mark_we = 1'b0;
    mark_addr = nb_idx;
    mark_wdata = MARK_DISC;
    list_we = 1'b0;
    list_waddr = fcount[IW-1:0];
    list_wdata = nb_idx;
    list_raddr = sel[IW-1:0];
    case (state)
      S_CLEAR: begin
        mark_we = 1'b1;
        mark_addr = clr[IW-1:0];
        mark_wdata = MARK_NONE;
      end
      S_MARK: begin
        mark_we = 1'b1;
        mark_addr = cur;
      end
      S_NCHK: begin
        if (nb_ok && mark_q == MARK_NONE && fcount < NW'(CELLS)) begin
          mark_we = 1'b1;
          mark_wdata = MARK_BOUND;
          list_we = 1'b1;
        end
      end
      // picked entry read straight from the remainder
      S_LRD: list_raddr = drem[IW-1:0];
      // last entry of the list moves into the picked slot
      S_LAST: list_raddr = IW'(fcount - NW'(1));
      S_LLGET: begin
        list_we = 1'b1;
        list_waddr = sel[IW-1:0];
        list_wdata = list_q;
      end
      default: ;
    endcase
  end

  assign in_ready = (state == S_IDLE) && !out_valid;

  logic start_mod;
  logic [15:0] mod_num;
  logic [NW-1:0] mod_den;
  assign dreq = '{start: start_mod, num: mod_num, den: mod_den};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      grid_rows <= 6'd10;
      grid_cols <= 6'd10;
      fcount <= '0;
      dcount <= '0;
      cur <= '0;
      running <= 1'b0;
      out_valid <= 1'b0;
      clr <= '0;
      start_mod <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (cfg_we) begin
        if (cfg_idx == REG_GRID_ROWS) grid_rows <= cfg_data;
        if (cfg_idx == REG_GRID_COLS) grid_cols <= cfg_data;
        running <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            item <= in_data;
            if (in_data.restart) begin
              clr <= '0;
              state <= S_CLEAR;
            end else if (running) begin
              state <= S_MARK;
            end
          end
        end
        S_CLEAR: begin
          clr <= clr + (IW+1)'(1);
          if (clr == (IW+1)'(CELLS - 1)) begin
            fcount <= '0;
            start_mod <= 1'b1;
            mod_num <= item.rand_start_row;
            mod_den <= NW'(rows);
            state <= S_WAITM;
            after_mod <= S_MODR;
          end
        end
        // start pulse lasts the first cycle of the wait
        S_WAITM: begin
          start_mod <= 1'b0;
          if (!dbusy && !start_mod) state <= after_mod;
        end
        S_MODR: begin
          cur[IW-1:CW] <= drem[RW-1:0];
          start_mod <= 1'b1;
          mod_num <= item.rand_start_col;
          mod_den <= NW'(cols);
          state <= S_WAITM;
          after_mod <= S_MODC;
        end
        S_MODC: begin
          cur[CW-1:0] <= drem[CW-1:0];
          dcount <= NW'(1);
          if (total > NW'(1)) begin
            running <= 1'b1;
            state <= S_MARK;
          end else begin
            running <= 1'b0;
            state <= S_IDLE;
          end
        end
        S_MARK: begin
          dir <= 2'd0;
          state <= S_NRD;
        end
        S_NRD: state <= S_NCHK;
        S_NCHK: begin
          if (nb_ok && mark_q == MARK_NONE && fcount < NW'(CELLS))
            fcount <= fcount + NW'(1);
          dir <= dir + 2'd1;
          state <= (dir == 2'd3) ? S_PICK : S_NRD;
        end
        S_PICK: begin
          if (fcount == '0) begin
            running <= 1'b0;
            state <= S_IDLE;
          end else begin
            start_mod <= 1'b1;
            mod_num <= item.rand_pick;
            mod_den <= fcount;
            state <= S_WAITM;
            after_mod <= S_LRD;
          end
        end
        S_LRD: begin
          sel <= drem;
          state <= S_LGET;
        end
        S_LGET: state <= S_BRD;
        S_BRD: state <= S_BCHK;
        S_BCHK: begin
          if (nb_ok && mark_q == MARK_DISC) begin
            nlist[ncount[1:0]] <= dir;
            ncount <= ncount + 3'd1;
          end
          dir <= dir + 2'd1;
          if (dir == 2'd3) state <= S_KMOD;
          else state <= S_BRD;
        end
        S_KMOD: begin
          if (ncount == 3'd0) begin
            running <= 1'b0;
            state <= S_IDLE;
          end else begin
            start_mod <= 1'b1;
            mod_num <= item.rand_neighbor;
            mod_den <= NW'(ncount);
            state <= S_WAITM;
            after_mod <= S_LAST;
          end
        end
        S_LAST: begin
          fcount <= fcount - NW'(1);
          state <= S_LLGET;
        end
        S_LLGET: state <= S_OUT;
        S_OUT: begin
          out_valid <= 1'b1;
          out_data.wall_kind <= ndir[0] ? 1'b0 : 1'b1;
          out_data.wall_row <= 5'(ndir == 2'd0 ? br - RW'(1) : br);
          out_data.wall_col <= 5'(ndir == 2'd1 ? bc - CW'(1) : bc);
          out_data.maze_done <= (dcount + NW'(1)) >= total;
          if ((dcount + NW'(1)) >= total) running <= 1'b0;
          dcount <= dcount + NW'(1);
          cur <= pick_cell;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
      if (state == S_LGET) begin
        pick_cell <= list_q;
        dir <= 2'd0;
        ncount <= '0;
      end
    end
  end

  `PMC_ASSERT_NOW(a_no_accept_busy, clk, rst, state != S_IDLE, !in_ready)
  `PMC_ASSERT_NOW(a_fcount_range, clk, rst, 1'b1, fcount <= NW'(CELLS))
  `PMC_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_data))
  `PMC_ASSERT_NOW(a_ncount_range, clk, rst, state == S_KMOD, ncount <= 3'd4)

endmodule
`default_nettype wire

/* hw/rtl/pmc_mod_unit.sv */
`default_nettype none
// shift-subtract remainder, one bit per cycle
module pmc_mod_unit import pmc_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire div_req_t req,
  output logic          busy,
  output logic [NW-1:0] rem
);
  logic [15:0] num;
  logic [NW:0] acc;
  logic [NW:0] trial;
  logic [4:0]  cnt;

  assign trial = {acc[NW-1:0], num[15]} - {1'b0, req.den};
  assign rem = acc[NW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      cnt <= 5'd16;
      num <= req.num;
      acc <= '0;
    end else if (busy) begin
      num <= {num[14:0], 1'b0};
      if (!trial[NW]) acc <= trial;
      else acc <= {acc[NW-1:0], num[15]};
      cnt <= cnt - 5'd1;
      if (cnt == 5'd1) busy <= 1'b0;
    end
  end
endmodule
`default_nettype wire

/* bench/tb_prim_maze_carver.sv */
`default_nettype none
module tb_prim_maze_carver;
  import pmc_pkg::*;

  // cycles with no handshake or register write before the run is abandoned: covers the
  // clearing pass after a restart, a full step and the longest output stall
  localparam int STALL_LIMIT = 20000;
  // quiet time before a register write: one clearing pass plus one step
  localparam int SETTLE_CYCLES = 1300;

  // carving predictor and store of expected walls
  class maze_scoreboard;
    logic [1:0]     mark [CELLS];
    int unsigned    flist [CELLS];
    int unsigned    fcount, disc, cur;
    bit             running;
    logic [5:0]     rows_reg, cols_reg;
    out_word_t      walls_due [$];
    int             errors;
    int             walls_seen, mazes_done, restarts;

    function new();
      foreach (mark[i]) mark[i] = MARK_NONE;
      foreach (flist[i]) flist[i] = 0;
      fcount = 0; disc = 0; cur = 0; running = 0;
      rows_reg = 6'd10; cols_reg = 6'd10;
      errors = 0; walls_seen = 0; mazes_done = 0; restarts = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == REG_GRID_ROWS) rows_reg = val;
      else cols_reg = val;
      running = 0;
    endfunction

    // out-of-range sizes act as the nearest legal one
    function int unsigned eff(logic [5:0] v, int unsigned lim);
      if (v == 0) return 1;
      if (v > lim) return lim;
      return 32'(v);
    endfunction

    function void add_bound(int r, int c, int unsigned nr, int unsigned nc);
      int unsigned id;
      if (r < 0 || c < 0 || r >= nr || c >= nc) return;
      id = r * MAX_COLS + c;
      if (mark[id] != MARK_NONE || fcount >= CELLS) return;
      mark[id] = MARK_BOUND;
      flist[fcount] = id;
      fcount++;
    endfunction

    function bit is_disc(int r, int c, int unsigned nr, int unsigned nc);
      if (r < 0 || c < 0 || r >= nr || c >= nc) return 0;
      return mark[r * MAX_COLS + c] == MARK_DISC;
    endfunction

    // one accepted input word: advance the maze and queue any wall
    function void note_input(in_word_t w);
      int unsigned nr, nc, sel, pick, n, k;
      int cr, cc, br, bc;
      int adj_r [4];
      int adj_c [4];
      out_word_t wall;
      nr = eff(rows_reg, MAX_ROWS);
      nc = eff(cols_reg, MAX_COLS);
      if (w.restart) begin
        foreach (mark[i]) mark[i] = MARK_NONE;
        fcount = 0;
        cur = (w.rand_start_row % nr) * MAX_COLS + (w.rand_start_col % nc);
        disc = 1;
        running = (nr * nc) > 1;
        restarts++;
      end
      if (!running) return;
      cr = cur / MAX_COLS;
      cc = cur % MAX_COLS;
      if (cr >= nr || cc >= nc) begin
        running = 0;
        return;
      end
      mark[cur] = MARK_DISC;
      add_bound(cr - 1, cc, nr, nc);
      add_bound(cr, cc - 1, nr, nc);
      add_bound(cr + 1, cc, nr, nc);
      add_bound(cr, cc + 1, nr, nc);
      if (fcount == 0) begin
        running = 0;
        return;
      end
      sel = w.rand_pick % fcount;
      pick = flist[sel] % CELLS;
      br = pick / MAX_COLS;
      bc = pick % MAX_COLS;
      n = 0;
      if (is_disc(br - 1, bc, nr, nc)) begin adj_r[n] = br - 1; adj_c[n] = bc; n++; end
      if (is_disc(br, bc - 1, nr, nc)) begin adj_r[n] = br; adj_c[n] = bc - 1; n++; end
      if (is_disc(br + 1, bc, nr, nc)) begin adj_r[n] = br + 1; adj_c[n] = bc; n++; end
      if (is_disc(br, bc + 1, nr, nc)) begin adj_r[n] = br; adj_c[n] = bc + 1; n++; end
      if (n == 0) begin
        running = 0;
        return;
      end
      k = w.rand_neighbor % n;
      if (adj_r[k] == br) begin
        wall.wall_kind = 1'b0;
        wall.wall_row = 5'(br);
        wall.wall_col = 5'((bc < adj_c[k]) ? bc : adj_c[k]);
      end else begin
        wall.wall_kind = 1'b1;
        wall.wall_row = 5'((br < adj_r[k]) ? br : adj_r[k]);
        wall.wall_col = 5'(bc);
      end
      fcount--;
      flist[sel] = flist[fcount];
      disc++;
      cur = pick;
      wall.maze_done = disc >= nr * nc;
      if (wall.maze_done) running = 0;
      walls_due.push_back(wall);
    endfunction

    task report(string what);
      $display("mismatch: %s", what);
      errors++;
    endtask

    task check_result(out_word_t got);
      out_word_t want;
      if (walls_due.size() == 0) begin
        report($sformatf("unexpected wall %p", got));
        return;
      end
      want = walls_due.pop_front();
      walls_seen++;
      if (want.maze_done) mazes_done++;
      if (got.wall_kind !== want.wall_kind)
        report($sformatf("wall_kind %0b, want %0b", got.wall_kind, want.wall_kind));
      if (got.wall_row !== want.wall_row)
        report($sformatf("wall_row %0d, want %0d", got.wall_row, want.wall_row));
      if (got.wall_col !== want.wall_col)
        report($sformatf("wall_col %0d, want %0d", got.wall_col, want.wall_col));
      if (got.maze_done !== want.maze_done)
        report($sformatf("maze_done %0b, want %0b", got.maze_done, want.maze_done));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_word_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_word_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  maze_scoreboard sb = new();
  int burst_left = 0;
  int idle_cycles = 0;

  always #5 clk = ~clk;

  prim_maze_carver uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  // output side: stall modes of their own, from always ready to long stalls
  int stall_mode = 0;
  int mode_left = 0;
  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      mode_left <= $urandom_range(20, 400);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 1) == 1);
      2: out_ready <= ($urandom_range(0, 9) == 0);
      default: out_ready <= ($urandom_range(0, 15) != 0);
    endcase
  end

  // result checking at each accepted output word
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(out_data);
  end

  // watchdog on cycles with no traffic at all
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we || rst)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no traffic for %0d cycles", STALL_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // sender in bursts: a gap only opens once the current burst runs out
  task send_word(in_word_t w);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (!in_ready);
    sb.note_input(w);
    burst_left--;
  endtask

  // wait for every expected wall, then for any step still in flight
  task settle();
    in_valid <= 1'b0;
    burst_left = 0;
    while (sb.walls_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task write_size(logic [5:0] r, logic [5:0] c);
    settle();
    cfg_we <= 1'b1;
    cfg_idx <= REG_GRID_ROWS;
    cfg_data <= r;
    @(posedge clk);
    sb.write_reg(REG_GRID_ROWS, r);
    cfg_idx <= REG_GRID_COLS;
    cfg_data <= c;
    @(posedge clk);
    sb.write_reg(REG_GRID_COLS, c);
    cfg_we <= 1'b0;
  endtask

  function logic [15:0] rand_field();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hffff;
      default: return 16'($urandom_range(0, 16'hffff));
    endcase
  endfunction

  // mostly complete mazes; some stray words while idle and a few aborts
  function in_word_t make_word();
    in_word_t w;
    w.rand_start_row = rand_field();
    w.rand_start_col = rand_field();
    w.rand_pick = rand_field();
    w.rand_neighbor = rand_field();
    if (!sb.running) w.restart = ($urandom_range(0, 99) < 85);
    else w.restart = ($urandom_range(0, 99) < 2);
    return w;
  endfunction

  task run_phase(logic [5:0] r, logic [5:0] c, int count);
    write_size(r, c);
    repeat (count) send_word(make_word());
  endtask

  function in_word_t word_of(bit rs, logic [15:0] sr, logic [15:0] sc,
                             logic [15:0] pk, logic [15:0] nb);
    in_word_t w;
    w.restart = rs;
    w.rand_start_row = sr;
    w.rand_start_col = sc;
    w.rand_pick = pk;
    w.rand_neighbor = nb;
    return w;
  endfunction

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    repeat (SETTLE_CYCLES) @(posedge clk);

    // directed: reset sizes, word before any restart is ignored
    send_word(word_of(1'b0, 16'hffff, 16'hffff, 16'hffff, 16'hffff));
    send_word(word_of(1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    send_word(word_of(1'b0, 16'h0000, 16'h0000, 16'hffff, 16'hffff));
    send_word(word_of(1'b1, 16'hffff, 16'hffff, 16'hffff, 16'h0000));
    repeat (6) send_word(word_of(1'b0, 16'h0, 16'h0, 16'hffff, 16'h0000));
    repeat (4) send_word(word_of(1'b0, 16'hffff, 16'hffff, 16'h0000, 16'hffff));

    // one-cell grid: a restart carves nothing
    write_size(6'd1, 6'd1);
    send_word(word_of(1'b1, 16'hffff, 16'hffff, 16'hffff, 16'hffff));
    send_word(word_of(1'b0, 16'h0, 16'h0, 16'h0, 16'h0));
    // zero rows acts as one; two cells finish in one step, then nothing
    write_size(6'd0, 6'd2);
    send_word(word_of(1'b1, 16'h0, 16'hffff, 16'h0, 16'h0));
    send_word(word_of(1'b0, 16'h0, 16'h0, 16'hffff, 16'hffff));
    // oversize registers clamp to the full grid; the write stops the maze
    write_size(6'd63, 6'd63);
    send_word(word_of(1'b1, 16'hffff, 16'h001f, 16'h1234, 16'h4321));
    send_word(word_of(1'b0, 16'h0, 16'h0, 16'h0, 16'h0));
    write_size(6'd63, 6'd63);
    send_word(word_of(1'b0, 16'h0, 16'h0, 16'h0, 16'h0));

    // random phases: the large grids only partly carved
    run_phase(6'd32, 6'd32, 90);
    run_phase(6'd63, 6'd40, 40);
    run_phase(6'd1, 6'd32, 50);
    run_phase(6'd32, 6'd1, 50);
    run_phase(6'd1, 6'd1, 10);
    run_phase(6'd0, 6'd0, 10);
    run_phase(6'd2, 6'd2, 40);
    for (int p = 0; p < 10; p++)
      run_phase(6'($urandom_range(1, 6)), 6'($urandom_range(1, 6)), 36);

    settle();
    $display("carved %0d walls in %0d completed mazes over %0d restarts",
             sb.walls_seen, sb.mazes_done, sb.restarts);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* prim_maze_carver.f */
+incdir+hw/rtl
hw/rtl/pmc_pkg.sv
hw/rtl/pmc_mod_unit.sv
hw/rtl/prim_maze_carver.sv
bench/tb_prim_maze_carver.sv
